@@ rtl/ckb_pkg.sv @@
// Shared types and constants for the chord-length knot builder.
// Depends on nothing; ckb_front, ckb_back and the top level import it.
package ckb_pkg;

   localparam int COORD_BITS     = 24;
   localparam int KNOT_FRAC_BITS = 16;
   localparam int KNOT_W         = KNOT_FRAC_BITS + 1;
   localparam int LEN_BITS       = 32;
   localparam int MAX_POINTS_DEF = 64;

   localparam logic [1:0]        MULT_END = 2'd2;
   localparam logic [1:0]        MULT_MID = 2'd1;
   localparam logic [KNOT_W-1:0] KNOT_ONE = KNOT_W'(1) << KNOT_FRAC_BITS;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] pt_x;
      logic signed [COORD_BITS-1:0] pt_y;
      logic signed [COORD_BITS-1:0] pt_z;
      logic                         final_point;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] ctrl_x;
      logic signed [COORD_BITS-1:0] ctrl_y;
      logic signed [COORD_BITS-1:0] ctrl_z;
      logic [KNOT_W-1:0]            knot_value;
      logic [1:0]                   multiplicity;
      logic                         degenerate;
      logic                         last_out;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
   } point_type;

   // classified item handed from the front to the back
   typedef struct packed {
      point_type pt;
      logic      keep;   // point goes into the store
      logic      first;  // first point of the run, zero segment length
      logic      fin;    // emit the run after this item
   } job_type;

endpackage

@@ rtl/ckb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module ckb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/ckb_front.sv @@
// Front end: accepts points, classifies them (first, kept, dropped, final)
// and holds them in a two-entry queue for the back end. Uses ckb_pkg.
module ckb_front import ckb_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  req_type          req_data,
   output logic             req_full,
   output logic             job_valid,
   input  logic             job_take,
   output job_type          job,
   output logic [CNT_W-1:0] job_cnt
);

   localparam int QDEPTH = 2;

   logic [CNT_W-1:0] count_ff;
   job_type          q_job_ff [QDEPTH];
   logic [CNT_W-1:0] q_cnt_ff [QDEPTH];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       fill_ff;

   logic             push, take, keep;
   logic [CNT_W-1:0] cnt_in;
   job_type          job_in;

   assign req_full  = (fill_ff == 2'(QDEPTH));
   assign job_valid = (fill_ff != 2'd0);
   assign push      = req_push && !req_full;
   assign take      = job_take && job_valid;

   assign keep   = (count_ff < CNT_W'(MAX_POINTS));
   assign cnt_in = keep ? CNT_W'(count_ff + 1'b1) : count_ff;

   always_comb begin
      job_in.pt.x  = req_data.pt_x;
      job_in.pt.y  = req_data.pt_y;
      job_in.pt.z  = req_data.pt_z;
      job_in.keep  = keep;
      job_in.first = (count_ff == '0);
      job_in.fin   = req_data.final_point;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            q_job_ff[wr_ptr_ff] <= job_in;
            q_cnt_ff[wr_ptr_ff] <= cnt_in;
            wr_ptr_ff           <= !wr_ptr_ff;
            count_ff            <= req_data.final_point ? '0 : cnt_in;
         end
         if (take) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         fill_ff <= 2'(fill_ff + {1'b0, push} - {1'b0, take});
      end
   end

   assign job     = q_job_ff[rd_ptr_ff];
   assign job_cnt = q_cnt_ff[rd_ptr_ff];

endmodule

@@ rtl/ckb_back.sv @@
// Back end: segment length (squares, iterative root), point store,
// and per-point knot division with the result register. Uses ckb_pkg, ckb_ram.
module ckb_back import ckb_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_take,
   input  job_type          job,
   input  logic [CNT_W-1:0] job_cnt,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rsp_type          rsp_data
);

   localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int D_W        = COORD_BITS + 1;
   localparam int SQ_W       = 2 * D_W;
   localparam int ACC_W      = SQ_W + 2;      // three squares never overflow
   localparam int ROOT_STEPS = ACC_W / 2;
   localparam int RS_W       = $clog2(ROOT_STEPS);
   localparam int DS_W       = $clog2(KNOT_W);
   localparam int ENT_W      = 3 * COORD_BITS + LEN_BITS;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SQ, ST_ROOT, ST_WRITE, ST_RD, ST_LD, ST_DIV, ST_OUT
   } state_type;

   state_type         state_ff;
   job_type           job_ff;
   point_type         prev_ff, epoint_ff;
   logic [CNT_W-1:0]  cnt_ff, n_ff;
   logic [1:0]        k_ff;
   logic [SQ_W-1:0]   sq_ff;
   logic [ACC_W-1:0]  acc_ff, v_ff, res_ff, bit_ff;
   logic [RS_W-1:0]   step_ff;
   logic [LEN_BITS-1:0] len_ff, total_ff;
   logic              degen_ff;
   logic [ADDR_W-1:0] idx_ff;
   logic [LEN_BITS:0] rem_ff;
   logic [KNOT_W-1:0] q_ff;
   logic [DS_W-1:0]   dstep_ff;
   rsp_type           out_ff;
   logic              out_valid_ff;

   logic signed [COORD_BITS-1:0] ca, cb;
   logic signed [D_W-1:0] diff;
   logic [D_W-1:0]    mag;
   logic [SQ_W-1:0]   sq;
   logic [ACC_W-1:0]  acc_in, trial, res_in;
   logic              ge;
   logic [LEN_BITS:0] tsum, r2;
   logic [LEN_BITS-1:0] total_in;
   logic              dge, out_free, out_load, is_last;
   logic [ENT_W-1:0]  rd_data;

   // one coordinate difference squared per cycle
   always_comb begin
      case (k_ff)
         2'd0:    begin ca = job_ff.pt.x; cb = prev_ff.x; end
         2'd1:    begin ca = job_ff.pt.y; cb = prev_ff.y; end
         default: begin ca = job_ff.pt.z; cb = prev_ff.z; end
      endcase
   end

   assign diff   = D_W'(ca) - D_W'(cb);
   assign mag    = diff[D_W-1] ? D_W'(-diff) : D_W'(diff);
   assign sq     = mag * mag;
   assign acc_in = acc_ff + ACC_W'(sq_ff);

   // restoring square root, one result bit per step
   assign trial  = res_ff + bit_ff;
   assign ge     = (v_ff >= trial);
   assign res_in = ge ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);

   assign tsum     = {1'b0, total_ff} + {1'b0, len_ff};
   assign total_in = tsum[LEN_BITS] ? '1 : tsum[LEN_BITS-1:0];

   // restoring division, one knot bit per step
   assign r2  = (dstep_ff == '0) ? rem_ff : {rem_ff[LEN_BITS-1:0], 1'b0};
   assign dge = (r2 >= {1'b0, total_ff});

   assign out_free = !out_valid_ff || rsp_pop;
   assign out_load = (state_ff == ST_OUT) && out_free;
   assign is_last  = (CNT_W'(idx_ff) == CNT_W'(n_ff - 1'b1));
   assign job_take = (state_ff == ST_IDLE) && job_valid;

   ckb_ram #(.WIDTH(ENT_W), .DEPTH(MAX_POINTS)) u_store (
      .clock   (clock),
      .wr_en   (state_ff == ST_WRITE),
      .wr_addr (ADDR_W'(cnt_ff - 1'b1)),
      .wr_data ({job_ff.pt, total_in}),
      .rd_en   (state_ff == ST_RD),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         total_ff     <= '0;
         prev_ff      <= '0;
      end else begin
         out_valid_ff <= out_load || (out_valid_ff && !rsp_pop);
         case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  job_ff <= job;
                  cnt_ff <= job_cnt;
                  k_ff   <= 2'd0;
                  acc_ff <= '0;
                  len_ff <= '0;
                  if (job.keep) begin
                     state_ff <= job.first ? ST_WRITE : ST_SQ;
                  end else if (job.fin) begin
                     n_ff     <= job_cnt;
                     degen_ff <= (job_cnt < CNT_W'(2)) || (total_ff == '0);
                     idx_ff   <= '0;
                     state_ff <= ST_RD;
                  end
               end
            end
            ST_SQ: begin
               sq_ff <= sq;
               k_ff  <= 2'(k_ff + 1'b1);
               if (k_ff != 2'd0) begin
                  acc_ff <= acc_in;
               end
               if (k_ff == 2'd3) begin
                  v_ff     <= acc_in;
                  res_ff   <= '0;
                  bit_ff   <= ACC_W'(1) << (ACC_W - 2);
                  step_ff  <= '0;
                  state_ff <= ST_ROOT;
               end
            end
            ST_ROOT: begin
               if (ge) begin
                  v_ff <= v_ff - trial;
               end
               res_ff  <= res_in;
               bit_ff  <= bit_ff >> 2;
               step_ff <= RS_W'(step_ff + 1'b1);
               if (step_ff == RS_W'(ROOT_STEPS - 1)) begin
                  len_ff   <= LEN_BITS'(res_in);
                  state_ff <= ST_WRITE;
               end
            end
            ST_WRITE: begin
               total_ff <= total_in;
               prev_ff  <= job_ff.pt;
               if (job_ff.fin) begin
                  n_ff     <= cnt_ff;
                  degen_ff <= (cnt_ff < CNT_W'(2)) || (total_in == '0);
                  idx_ff   <= '0;
                  state_ff <= ST_RD;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_RD: begin
               state_ff <= ST_LD;
            end
            ST_LD: begin
               epoint_ff <= rd_data[ENT_W-1:LEN_BITS];
               rem_ff    <= {1'b0, rd_data[LEN_BITS-1:0]};
               q_ff      <= '0;
               dstep_ff  <= '0;
               state_ff  <= degen_ff ? ST_OUT : ST_DIV;
            end
            ST_DIV: begin
               rem_ff   <= dge ? (r2 - {1'b0, total_ff}) : r2;
               q_ff     <= {q_ff[KNOT_W-2:0], dge};
               dstep_ff <= DS_W'(dstep_ff + 1'b1);
               if (dstep_ff == DS_W'(KNOT_W - 1)) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  out_ff.ctrl_x       <= epoint_ff.x;
                  out_ff.ctrl_y       <= epoint_ff.y;
                  out_ff.ctrl_z       <= epoint_ff.z;
                  out_ff.knot_value   <= q_ff;
                  out_ff.multiplicity <= ((idx_ff == '0) || is_last) ? MULT_END : MULT_MID;
                  out_ff.degenerate   <= degen_ff;
                  out_ff.last_out     <= is_last;
                  if (is_last) begin
                     total_ff <= '0;
                     prev_ff  <= '0;
                     state_ff <= ST_IDLE;
                  end else begin
                     idx_ff   <= ADDR_W'(idx_ff + 1'b1);
                     state_ff <= ST_RD;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   a_store_addr: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE |-> cnt_ff != '0 && cnt_ff <= CNT_W'(MAX_POINTS))
      else $error("store write outside the run");
   a_last_mult: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && out_ff.last_out |-> out_ff.multiplicity == MULT_END)
      else $error("last item without end multiplicity");
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && out_ff.degenerate |-> out_ff.knot_value == '0)
      else $error("degenerate run with nonzero knot");
   a_last_one: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && out_ff.last_out && !out_ff.degenerate |-> out_ff.knot_value == KNOT_ONE)
      else $error("last knot of a run is not 1.0");
`endif

endmodule

@@ rtl/chord_length_knot_builder.sv @@
// Top level of the chord-length knot builder: front end, queue, back end.
// Uses ckb_pkg, ckb_front, ckb_back (which holds the ckb_ram point store).
//
// Points come in one item at a time on the req_ side; each kept point goes
// through the back end in order: it is taken from the queue, the three
// coordinate differences are squared and summed through one shared
// multiplier, the one-bit-per-cycle square root of the 52-bit sum is taken,
// and the length is added and written to the store. The first point of a
// run skips the squares and the root. Points past MAX_POINTS are dropped at
// once. The item marked final_point starts emission: each stored point
// comes out as one rsp_ item after a store read, a 17-step knot division
// and a load of the result register; a degenerate run skips the division.
// The front queue holds two items, so the producer keeps pushing while
// the back end works. The result register holds one finished item; while
// the consumer stalls, the back end waits in its output step and the
// front queue takes up to two more points before req_full rises. No new
// point is processed while a run is being emitted.
module chord_length_knot_builder import ckb_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   logic             job_valid, job_take;
   job_type          job;
   logic [CNT_W-1:0] job_cnt;

   // classify and queue incoming points
   ckb_front #(.MAX_POINTS(MAX_POINTS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .job_valid (job_valid),
      .job_take  (job_take),
      .job       (job),
      .job_cnt   (job_cnt)
   );

   // lengths, store and knot emission
   ckb_back #(.MAX_POINTS(MAX_POINTS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_take  (job_take),
      .job       (job),
      .job_cnt   (job_cnt),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

@@ verif/tb_chord_length_knot_builder.sv @@
// Self-checking bench for chord_length_knot_builder: points go in, knot entries come out.
// Depends on ckb_pkg and the RTL top; has its own chord-length knot predictor.
`timescale 1ns / 100ps

module tb_chord_length_knot_builder;
   import ckb_pkg::*;

   localparam int  MAX_PTS     = MAX_POINTS_DEF;
   localparam int  N_RANDOM    = 460;
   localparam int  QUIET_AFTER = 420;      // no idling on either side past this item
   localparam int  LONG_HOLD   = 700;      // receiver back-pressure stretch, cycles
   localparam int  HOLD_AT     = 150;      // item count that triggers the stretch
   localparam int  DRAIN_WAIT  = 60;
   localparam longint CYCLE_LIMIT = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   always #10 clock = ~clock;

   chord_length_knot_builder u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

   // ---------------------------------------------------------------
   // Predictor state: a private copy of the run being collected.
   // ---------------------------------------------------------------
   point_type        run_pts [MAX_PTS];
   logic [31:0]      run_cum [MAX_PTS];
   int               run_count;
   logic [31:0]      run_total;
   point_type        prev_pt;

   rsp_type knots_due[$];     // expected knot entries, oldest first
   int      mismatches;
   int      items_sent;
   bit      quiet;

   // integer square root, rounded down
   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned chord(point_type a, point_type b);
      longint signed   d [3];
      longint unsigned acc;
      longint unsigned sq;
      d[0] = longint'(a.x) - longint'(b.x);
      d[1] = longint'(a.y) - longint'(b.y);
      d[2] = longint'(a.z) - longint'(b.z);
      acc = 0;
      foreach (d[k]) begin
         sq = longint'(d[k] < 0 ? -d[k] : d[k]);
         sq = sq * sq;
         acc = (acc > ~64'd0 - sq) ? ~64'd0 : acc + sq;
      end
      return floor_sqrt(acc);
   endfunction

   // Update the run with one accepted point; queue the knot entries on final.
   task automatic predict_point(req_type r);
      point_type       p;
      longint unsigned seg;
      longint unsigned tot;
      longint unsigned kv;
      rsp_type         e;
      bit              degen;
      p = '{x: r.pt_x, y: r.pt_y, z: r.pt_z};
      if (run_count < MAX_PTS) begin
         seg = (run_count == 0) ? 0 : chord(p, prev_pt);
         tot = longint'(run_total) + seg;
         run_total = (tot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : tot[31:0];
         run_pts[run_count] = p;
         run_cum[run_count] = run_total;
         prev_pt = p;
         run_count++;
      end
      if (!r.final_point) return;
      degen = (run_count < 2) || (run_total == 0);
      for (int i = 0; i < run_count; i++) begin
         kv = 0;
         if (!degen) begin
            kv = (longint'(run_cum[i]) << KNOT_FRAC_BITS) / longint'(run_total);
            if (kv > KNOT_ONE) kv = KNOT_ONE;
         end
         e.ctrl_x       = run_pts[i].x;
         e.ctrl_y       = run_pts[i].y;
         e.ctrl_z       = run_pts[i].z;
         e.knot_value   = kv[KNOT_W-1:0];
         e.multiplicity = (i == 0 || i == run_count - 1) ? MULT_END : MULT_MID;
         e.degenerate   = degen;
         e.last_out     = (i == run_count - 1);
         knots_due.push_back(e);
      end
      run_count = 0;
      run_total = '0;
      prev_pt   = '0;
   endtask

   // ---------------------------------------------------------------
   // Directed rows. A row with a typed expectation ends a one-point
   // run, so its single entry can be written down directly.
   // ---------------------------------------------------------------
   typedef struct {
      req_type r;
      bit      typed;
      rsp_type e;
   } row_type;

   localparam logic signed [23:0] CMAX = 24'sh7FFFFF;
   localparam logic signed [23:0] CMIN = 24'sh800000;

   row_type rows[] = '{
      // lone point at the origin: degenerate, end multiplicity
      '{'{24'sd0, 24'sd0, 24'sd0, 1'b1}, 1'b1,
        '{24'sd0, 24'sd0, 24'sd0, '0, MULT_END, 1'b1, 1'b1}},
      // lone point at the extremes
      '{'{CMAX, CMIN, CMAX, 1'b1}, 1'b1,
        '{CMAX, CMIN, CMAX, '0, MULT_END, 1'b1, 1'b1}},
      // two coincident points: zero total length
      '{'{24'sd5, -24'sd7, 24'sd9, 1'b0}, 1'b0, '{default: '0}},
      '{'{24'sd5, -24'sd7, 24'sd9, 1'b1}, 1'b0, '{default: '0}},
      // corner to corner, longest segment
      '{'{CMIN, CMIN, CMIN, 1'b0}, 1'b0, '{default: '0}},
      '{'{CMAX, CMAX, CMAX, 1'b1}, 1'b0, '{default: '0}},
      // three points, uneven chords (3-4-5 then 12)
      '{'{24'sd0, 24'sd0, 24'sd0, 1'b0}, 1'b0, '{default: '0}},
      '{'{24'sd3, 24'sd4, 24'sd0, 1'b0}, 1'b0, '{default: '0}},
      '{'{24'sd3, 24'sd4, 24'sd12, 1'b1}, 1'b0, '{default: '0}},
      // repeated middle point, then back to start
      '{'{-24'sd1, -24'sd1, -24'sd1, 1'b0}, 1'b0, '{default: '0}},
      '{'{24'sd1, 24'sd1, 24'sd1, 1'b0}, 1'b0, '{default: '0}},
      '{'{24'sd1, 24'sd1, 24'sd1, 1'b0}, 1'b0, '{default: '0}},
      '{'{-24'sd1, -24'sd1, -24'sd1, 1'b1}, 1'b0, '{default: '0}},
      // alternating bit patterns on x and y, small values on z
      '{'{24'sh555555, 24'shAAAAAA, 24'sh000001, 1'b0}, 1'b0, '{default: '0}},
      '{'{24'shAAAAAA, 24'sh555555, 24'shFFFFFE, 1'b1}, 1'b0, '{default: '0}}
   };

   // ---------------------------------------------------------------
   // Sender: one item per call, random gap bursts before it.
   // ---------------------------------------------------------------
   task automatic send_point(req_type r);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_full);
      predict_point(r);
      items_sent++;
      if (items_sent >= QUIET_AFTER) quiet = 1'b1;
   endtask

   function automatic logic signed [23:0] rand_coord(bit wide);
      if (wide) return 24'($urandom());
      return $signed(24'($urandom_range(0, 4000))) - 24'sd2000;
   endfunction

   // ---------------------------------------------------------------
   // Receiver: checks every accepted entry, stalls in bursts, and once
   // holds off for a long stretch so the input side backs up.
   // ---------------------------------------------------------------
   int  stall_left;
   bit  long_hold_done;

   always @(posedge clock) begin
      rsp_type e;
      if (rsp_pop && !rsp_empty && !reset) begin
         if (knots_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected knot entry %p", rsp_data);
         end else begin
            e = knots_due.pop_front();
            if (rsp_data !== e) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("knot entry mismatch: expected %p got %p", e, rsp_data);
            end
         end
      end
      if (!long_hold_done && items_sent >= HOLD_AT) begin
         long_hold_done <= 1'b1;
         stall_left <= LONG_HOLD;
         rsp_pop <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 12);
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // run-time guard
   longint cycles;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("chord_length_knot_builder regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      int n;
      bit wide;
      req_type r;
      run_count = 0; run_total = '0; prev_pt = '0;
      mismatches = 0; items_sent = 0; quiet = 1'b0;
      stall_left = 0; long_hold_done = 1'b0; cycles = 0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         send_point(rows[i].r);
         if (rows[i].typed) knots_due[$] = rows[i].e;
      end

      // random runs: mostly short, some single points, a few overfill the store
      while (items_sent < rows.size() + N_RANDOM) begin
         case ($urandom_range(0, 19))
            0:       n = 1;
            1:       n = $urandom_range(MAX_PTS - 2, MAX_PTS + 6);
            default: n = $urandom_range(2, 9);
         endcase
         wide = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < n; k++) begin
            r.pt_x = rand_coord(wide);
            r.pt_y = rand_coord(wide);
            r.pt_z = rand_coord(wide);
            // occasional repeat of the last point: zero-length segment
            if ($urandom_range(0, 9) == 0 && k > 0) begin
               r.pt_x = prev_pt.x; r.pt_y = prev_pt.y; r.pt_z = prev_pt.z;
            end
            r.final_point = (k == n - 1);
            send_point(r);
         end
      end
      req_push <= 1'b0;

      while (knots_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatches == 0 && knots_due.size() == 0) begin
         $display("chord_length_knot_builder regression: pass");
      end else begin
         $display("chord_length_knot_builder regression: fail");
      end
      $finish;
   end

endmodule
